// ===== hdl/afd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package afd_pkg;

	localparam int unsigned AFD_NUM_BOOKS = 16;
	localparam int unsigned BOOK_WORDS    = 16;
	localparam int unsigned HALF          = 8;
	localparam int unsigned ADDR_W        = 8;
	localparam int unsigned BOOK_W        = 4;
	localparam int unsigned SAMPLE_W      = 16;
	localparam int unsigned ACC_W         = 32;
	localparam int unsigned FRAC_SHIFT    = 11;
	localparam int unsigned MAX_SHIFT     = 12;
	// sum of up to seven coef * nibble products
	localparam int unsigned RS_W          = 22;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_HIST   = 2'd1;
	localparam logic [1:0] ACT_DECODE = 2'd2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [3:0]          nib_t;

endpackage

`default_nettype wire

// ===== hdl/afd_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface afd_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [7:0]        header;
	logic [31:0]       residuals_first;
	logic [31:0]       residuals_second;
	logic [7:0]        coef_addr;
	logic signed [15:0] coef_value;
	logic signed [15:0] history_older;
	logic signed [15:0] history_newer;

	modport source (output valid, action, header, residuals_first, residuals_second,
		coef_addr, coef_value, history_older, history_newer, input ready);
	modport sink (input valid, action, header, residuals_first, residuals_second,
		coef_addr, coef_value, history_older, history_newer, output ready);
endinterface

interface afd_rsp_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] pcm0;
	logic signed [15:0] pcm1;
	logic signed [15:0] pcm2;
	logic signed [15:0] pcm3;
	logic signed [15:0] pcm4;
	logic signed [15:0] pcm5;
	logic signed [15:0] pcm6;
	logic signed [15:0] pcm7;
	logic              last_of_frame;

	modport source (output valid, pcm0, pcm1, pcm2, pcm3, pcm4, pcm5, pcm6, pcm7,
		last_of_frame, input ready);
	modport sink (input valid, pcm0, pcm1, pcm2, pcm3, pcm4, pcm5, pcm6, pcm7,
		last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== hdl/afd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module afd_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/afd_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module afd_lane import afd_pkg::*; #(
	parameter int unsigned LANE = 0
) (
	input  wire logic    clk,
	input  wire logic    mul_en,
	input  wire logic    add_en,
	input  wire sample_t c0,
	input  wire sample_t c1 [HALF],
	input  wire nib_t    nib [HALF],
	input  wire logic [3:0] sh,
	input  wire sample_t hist_old,
	input  wire sample_t hist_new,
	output sample_t      pcm_d,
	output sample_t      pcm_q
);

	logic signed [ACC_W-1:0] p_old_s1;
	logic signed [ACC_W-1:0] p_new_s1;
	logic signed [RS_W-1:0]  rs_s1;
	nib_t                    n_s1;
	logic [3:0]              sh_s1;

	logic signed [RS_W-1:0]  rs_d;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] scaled;

	// residual taps: earlier samples of this half weighted by row 1
	always_comb begin
		rs_d = '0;
		for (int j = 0; j < LANE; j++) begin
			rs_d = rs_d + c1[LANE-1-j] * nib[j];
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			p_old_s1 <= c0 * hist_old;
			p_new_s1 <= c1[LANE] * hist_new;
			rs_s1    <= rs_d;
			n_s1     <= nib[LANE];
			sh_s1    <= sh;
		end
	end

	always_comb begin
		acc = p_old_s1 + p_new_s1 + (ACC_W'(rs_s1) <<< sh_s1)
			+ (ACC_W'(n_s1) <<< (5'(sh_s1) + 5'(FRAC_SHIFT)));
		scaled = acc >>> FRAC_SHIFT;
		if (scaled > ACC_W'(32'sd32767)) begin
			pcm_d = 16'sh7fff;
		end else if (scaled < -ACC_W'(32'sd32768)) begin
			pcm_d = 16'sh8000;
		end else begin
			pcm_d = scaled[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (add_en) begin
			pcm_q <= pcm_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/adpcm_frame_decoder.sv =====
// Decode item: the codebook read, the product registers and the output register lie between the
// input transfer and the first half-frame; each half waits while the output register is full.
// A decode item holds the input through states MUL0, ADD0, MUL1 and ADD1; load and history items do not.
// Rate is set by the two dependent half-frames: the second half predicts from the first.
// arst_n clears the sequencer, output valid and history; the codebook RAMs are not reset.
`timescale 1ns / 1ps
`default_nettype none

module adpcm_frame_decoder import afd_pkg::*; #(
	parameter int unsigned NUM_BOOKS = AFD_NUM_BOOKS
) (
	input wire logic clk,
	input wire logic arst_n,
	afd_req_if.sink   req,
	afd_rsp_if.source rsp
);

	localparam int unsigned AW = (NUM_BOOKS > 1) ? $clog2(NUM_BOOKS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL0 = 3'd1;
	localparam logic [2:0] ST_ADD0 = 3'd2;
	localparam logic [2:0] ST_MUL1 = 3'd3;
	localparam logic [2:0] ST_ADD1 = 3'd4;

	logic [2:0]  state_q;
	logic        req_xfer;
	logic        addr_ok;
	logic        book_ok;
	logic        add_fire;
	logic        mul_en;
	logic        out_valid_q;
	logic        last_q;
	logic        book_ok_q;
	logic [3:0]  sh_q;
	logic [31:0] res_first_q;
	logic [31:0] res_second_q;
	logic [31:0] res_sel;
	sample_t     hist_old_q;
	sample_t     hist_new_q;

	logic [SAMPLE_W-1:0] rdata [BOOK_WORDS];
	sample_t c0 [HALF];
	sample_t c1 [HALF];
	nib_t    nib [HALF];
	sample_t pcm_d [HALF];
	sample_t pcm_q [HALF];

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign addr_ok   = {1'b0, req.coef_addr} < (ADDR_W + 1)'(NUM_BOOKS * BOOK_WORDS);
	assign book_ok   = {1'b0, req.header[BOOK_W-1:0]} < (BOOK_W + 1)'(NUM_BOOKS);
	assign mul_en    = (state_q == ST_MUL0) || (state_q == ST_MUL1);
	assign add_fire  = ((state_q == ST_ADD0) || (state_q == ST_ADD1))
		&& (!out_valid_q || rsp.ready);

	for (genvar k = 0; k < BOOK_WORDS; k++) begin : g_ram
		afd_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_BOOKS)) u_ram (
			.clk   (clk),
			.we    (req_xfer && req.action == ACT_LOAD && addr_ok
				&& req.coef_addr[3:0] == 4'(k)),
			.waddr (req.coef_addr[4 +: AW]),
			.wdata (req.coef_value),
			.re    (req_xfer && req.action == ACT_DECODE),
			.raddr (req.header[0 +: AW]),
			.rdata (rdata[k])
		);
	end

	assign res_sel = (state_q == ST_MUL1) ? res_second_q : res_first_q;

	always_comb begin
		for (int i = 0; i < HALF; i++) begin
			c0[i]  = book_ok_q ? rdata[i] : '0;
			c1[i]  = book_ok_q ? rdata[i + HALF] : '0;
			nib[i] = res_sel[31 - 4 * i -: 4];
		end
	end

	for (genvar i = 0; i < HALF; i++) begin : g_lane
		afd_lane #(.LANE(i)) u_lane (
			.clk      (clk),
			.mul_en   (mul_en),
			.add_en   (add_fire),
			.c0       (c0[i]),
			.c1       (c1),
			.nib      (nib),
			.sh       (sh_q),
			.hist_old (hist_old_q),
			.hist_new (hist_new_q),
			.pcm_d    (pcm_d[i]),
			.pcm_q    (pcm_q[i])
		);
	end

	always_ff @(posedge clk) begin
		if (req_xfer && req.action == ACT_DECODE) begin
			book_ok_q    <= book_ok;
			sh_q         <= (req.header[7:4] < 4'(MAX_SHIFT)) ? req.header[7:4]
				: 4'(MAX_SHIFT);
			res_first_q  <= req.residuals_first;
			res_second_q <= req.residuals_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			hist_old_q  <= '0;
			hist_new_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_xfer && req.action == ACT_DECODE) begin
						state_q <= ST_MUL0;
					end
				end
				ST_MUL0: state_q <= ST_ADD0;
				ST_ADD0: begin
					if (add_fire) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_ADD1;
				ST_ADD1: begin
					if (add_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (req_xfer && req.action == ACT_HIST) begin
				hist_old_q <= req.history_older;
				hist_new_q <= req.history_newer;
			end else if (add_fire) begin
				hist_old_q <= pcm_d[HALF-2];
				hist_new_q <= pcm_d[HALF-1];
			end

			if (add_fire) begin
				out_valid_q <= 1'b1;
				last_q      <= (state_q == ST_ADD1);
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.last_of_frame = last_q;
	assign rsp.pcm0          = pcm_q[0];
	assign rsp.pcm1          = pcm_q[1];
	assign rsp.pcm2          = pcm_q[2];
	assign rsp.pcm3          = pcm_q[3];
	assign rsp.pcm4          = pcm_q[4];
	assign rsp.pcm5          = pcm_q[5];
	assign rsp.pcm6          = pcm_q[6];
	assign rsp.pcm7          = pcm_q[7];

endmodule

`default_nettype wire

// ===== hdl/afd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module afd_checker import afd_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic [1:0]  req_action,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic        rsp_last,
	input wire logic [15:0] rsp_pcm0
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pcm0) && $stable(rsp_last))
		else $error("result changed while stalled");

	// no new item while the second half of a frame is still to come
	a_first_half_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> !req_ready)
		else $error("input ready while first half pending");

	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_action == ACT_DECODE |=> !req_ready)
		else $error("input ready right after decode transfer");

	a_other_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_action != ACT_DECODE && !rsp_valid
		|=> !rsp_valid && req_ready)
		else $error("non-decode item produced a result or stalled");

endmodule

bind adpcm_frame_decoder afd_checker u_afd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_action (req.action),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_last   (rsp.last_of_frame),
	.rsp_pcm0   (rsp.pcm0)
);

`default_nettype wire
